FILE: hw/rtl/kpd_pkg.sv
// Types, constants and the key decode table for the keypad scan/debounce block.
// No dependencies; used by kpd_core and keypad_scan_debounce_top.
package kpd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_DETECT  = 2'd1,
    PH_PRESSED = 2'd2,
    PH_RELEASE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_e;

  localparam logic [7:0]  ROW_MASK       = 8'b0111_1000;
  localparam logic [7:0]  COL_MASK       = 8'b0000_0111;
  localparam logic [7:0]  COL_FIRST      = 8'b0000_0110;
  localparam logic [7:0]  COL_SET        = 8'b0000_0001;
  localparam logic [3:0]  DP_CODE        = 4'hc;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
  localparam int unsigned NUM_KEYS       = 12;

  localparam logic [7:0] KEY_PATTERN [NUM_KEYS] = '{
    8'h46, 8'h26, 8'h16, 8'h43, 8'h45, 8'h23,
    8'h25, 8'h13, 8'h15, 8'h0d, 8'h0b, 8'h0e
  };
  localparam logic [3:0] KEY_CODE [NUM_KEYS] = '{
    4'd3, 4'd6, 4'd9, 4'd1, 4'd2, 4'd4,
    4'd5, 4'd7, 4'd8, 4'd0, 4'd10, 4'd11
  };

  typedef struct packed {
    logic       column_write;
    logic [7:0] column_drive;
    event_e     event_kind;
    logic [3:0] key_value;
    logic [3:0] display_value;
  } kpd_res_t;

endpackage

FILE: hw/rtl/kpd_core.sv
// Scan/debounce state machine: key decode, phase, snapshot and debounce timer.
// Processes one poll per step_i pulse; depends on kpd_pkg.
module kpd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       port_i,
  input  logic [15:0]      debounce_polls_i,
  output kpd_pkg::kpd_res_t res_o
);
  import kpd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic [3:0]  decoded_q, decoded_d;
  logic [3:0]  reported_q, reported_d;
  logic [15:0] left_q, left_d;

  logic [15:0] left_dec;
  logic        expired;
  logic        rows_active;
  logic [7:0]  col_next;

  // Decode the snapshot taken on an earlier poll; keep the old key on no match.
  always_comb begin
    decoded_d = decoded_q;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (KEY_PATTERN[i] == held_q) begin
        decoded_d = KEY_CODE[i];
      end
    end
  end

  assign left_dec    = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
  assign expired     = (left_dec == 16'd0);
  assign rows_active = |(port_i & ROW_MASK);

  always_comb begin
    col_next = {port_i[6:0], 1'b0} | COL_SET;
    if ((col_next & COL_MASK) == COL_MASK) begin
      col_next = COL_FIRST;
    end
  end

  // Next state
  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    reported_d = reported_q;
    left_d     = left_q;
    case (phase_q)
      PH_IDLE: begin
        if (rows_active) begin
          held_d  = port_i;
          left_d  = debounce_polls_i;
          phase_d = PH_DETECT;
        end
      end
      PH_DETECT: begin
        left_d = left_dec;
        if (expired) begin
          if (port_i == held_q) begin
            reported_d = decoded_d;
            phase_d    = PH_PRESSED;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (port_i != held_q) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    res_o = '{column_write: 1'b0, column_drive: 8'd0, event_kind: EV_NONE,
              key_value: 4'd0, display_value: 4'd0};
    case (phase_q)
      PH_IDLE: begin
        if (!rows_active) begin
          res_o.column_write = 1'b1;
          res_o.column_drive = col_next;
        end
      end
      PH_DETECT: begin
        if (expired && (port_i == held_q)) begin
          res_o.event_kind    = EV_PRESS;
          res_o.key_value     = decoded_d;
          res_o.display_value = decoded_d;
        end
      end
      PH_PRESSED: begin
        if (port_i != held_q) begin
          res_o.event_kind    = EV_RELEASE;
          res_o.key_value     = reported_q;
          res_o.display_value = DP_CODE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      held_q     <= 8'd0;
      decoded_q  <= 4'd0;
      reported_q <= 4'd0;
      left_q     <= 16'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      held_q     <= held_d;
      decoded_q  <= decoded_d;
      reported_q <= reported_d;
      left_q     <= left_d;
    end
  end

`ifndef SYNTHESIS
  a_press_enters_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.event_kind == EV_PRESS |=>
      phase_q == PH_PRESSED && reported_q == $past(res_o.key_value))
    else $error("press beat did not latch key and enter pressed phase");

  a_no_release_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_RELEASE)
    else $error("unreachable release phase entered");

  a_drive_only_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.column_write |->
      res_o.event_kind == EV_NONE && res_o.column_drive[2:0] != 3'b111)
    else $error("column drive with event or all columns deselected");

  a_idle_row_detect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_IDLE && !res_o.column_write |=>
      phase_q == PH_DETECT && left_q == $past(debounce_polls_i))
    else $error("row hit in idle did not arm debounce timer");
`endif

endmodule

FILE: hw/rtl/keypad_scan_debounce_top.sv
// Top level of the keypad scan/debounce block: input register, result register,
// debounce configuration register. Depends on kpd_pkg and kpd_core.
//
// Usage: each s_axis beat carries one poll of the 8-bit keypad port. For
// every poll one m_axis beat comes out: a column drive byte to write back
// (tuser[0] set), a key event (tuser[2:1]: 1 press, 2 release) with the
// key 0..11 and the display code (12 on release), or neither.
// The cfg channel sets the debounce length in polls (reset value 10); write
// it only while no poll is in flight. cfg_ready_o is always high.
// An accepted poll passes the input register, then the result register, before
// it is presented on m_axis. Throughput: one poll per cycle while the receiver
// does not stall; kpd_core updates its state once per poll.
// When the receiver stalls, the result register holds and the input register
// fills; s_axis_tready drops only when both are full.
// Reset (rst_ni low) empties both registers, returns the scanner to idle and
// clears snapshot, keys and timer.
module keypad_scan_debounce_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] port_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] column_drive, [11:8] key_value,
                                      // [15:12] display_value
  output logic [2:0]  m_axis_tuser,   // [0] column_write, [2:1] event_kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import kpd_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_port_q;
  logic        out_valid_q;
  kpd_res_t    out_res_q;
  kpd_res_t    res;
  logic [15:0] debounce_q;
  logic        advance;
  logic        in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      debounce_q <= cfg_data_i;
    end
  end

  // Move the held poll into the result register when that slot frees up.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_port_q <= s_axis_tdata;
    end
  end

  kpd_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .port_i           (in_port_q),
    .debounce_polls_i (debounce_q),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.display_value, out_res_q.key_value,
                          out_res_q.column_drive};
  assign m_axis_tuser  = {out_res_q.event_kind, out_res_q.column_write};

endmodule
